### design/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg : shared types and constants
// Byte type, S-box geometry and the request/response structs that pass
// between the top level and the cipher sequencer.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int SBOX_DEPTH = 256;
    localparam int SBOX_AW    = 8;

    typedef logic [7:0] byte_t;

    // S-box address of the last entry: ends the fill and the key schedule
    localparam logic [SBOX_AW-1:0] SBOX_LAST = 8'hFF;

    // operation codes
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef struct packed {
        logic  accept;
        logic  operation;
        byte_t byte_in;
        logic  last_key_byte;
    } rc4_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        byte_t result;
    } rc4_rsp_t;

endpackage

### design/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4_ram : generic single-write, single-read RAM
// One write port, one read port, registered read data (read-first).
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// rc4_ctrl : RC4 sequencer around the S-box and key store RAMs
// Stores key bytes, runs identity fill plus key schedule, and generates
// one keystream byte per data transaction using the shared S-box port.
// ----------------------------------------------------------------------------
module rc4_ctrl
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic     clk,
    input  logic     rst_n,
    input  rc4_req_t req,
    input  logic     out_ready,
    output rc4_rsp_t rsp
);

    localparam int KCW = $clog2(MAX_KEY_BYTES + 1);
    localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [KCW-1:0] KEY_MAX = KCW'(MAX_KEY_BYTES);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_FILL   = 4'd1;
    localparam logic [3:0] ST_KS_RD  = 4'd2;
    localparam logic [3:0] ST_KS_ACC = 4'd3;
    localparam logic [3:0] ST_KS_W1  = 4'd4;
    localparam logic [3:0] ST_KS_W2  = 4'd5;
    localparam logic [3:0] ST_D_RDJ  = 4'd6;
    localparam logic [3:0] ST_D_W1   = 4'd7;
    localparam logic [3:0] ST_D_W2   = 4'd8;
    localparam logic [3:0] ST_D_RDT  = 4'd9;
    localparam logic [3:0] ST_D_KS   = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic [KCW-1:0]     key_count_reg, key_count_next;
    logic [KCW-1:0]     len_reg, len_next;
    logic [KAW-1:0]     pos_reg, pos_next;
    logic [SBOX_AW-1:0] n_reg, n_next;
    logic [SBOX_AW-1:0] acc_reg, acc_next;
    logic [SBOX_AW-1:0] i_reg, i_next;
    logic [SBOX_AW-1:0] j_reg, j_next;
    logic               keyed_reg, keyed_next;
    byte_t              si_reg, si_next;
    byte_t              sj_reg, sj_next;
    byte_t              data_reg, data_next;

    // S-box RAM port
    logic               s_we;
    logic [SBOX_AW-1:0] s_waddr;
    byte_t              s_wdata;
    logic [SBOX_AW-1:0] s_raddr;
    byte_t              s_rdata;

    // key store port
    logic               k_we;
    byte_t              k_rdata;
    logic               key_store_en;
    logic [SBOX_AW-1:0] acc_sum;

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (MAX_KEY_BYTES)
    ) u_key (
        .clk   (clk),
        .we    (k_we),
        .waddr (key_count_reg[KAW-1:0]),
        .wdata (req.byte_in),
        .raddr (pos_reg),
        .rdata (k_rdata)
    );

    assign key_store_en = (key_count_reg < KEY_MAX);
    assign k_we = (state_reg == ST_IDLE) && req.accept && (req.operation == OP_KEY)
                  && key_store_en;
    assign acc_sum = acc_reg + k_rdata + s_rdata;

    always_comb
    begin
        state_next     = state_reg;
        key_count_next = key_count_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        keyed_next     = keyed_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        data_next      = data_reg;
        s_we           = 1'b0;
        s_waddr        = n_reg;
        s_wdata        = n_reg;
        s_raddr        = n_reg;
        rsp.busy       = (state_reg != ST_IDLE);
        rsp.done       = 1'b0;
        rsp.result     = data_reg ^ s_rdata;

        unique case (state_reg)
            ST_IDLE:
            begin
                // pre-read S[i+1] so it is ready the cycle after a data accept
                s_raddr = i_reg + 8'd1;
                if (req.accept)
                begin
                    if (req.operation == OP_KEY)
                    begin
                        if (key_store_en)
                        begin
                            key_count_next = key_count_reg + KCW'(1);
                        end
                        if (req.last_key_byte)
                        begin
                            len_next       = key_store_en ? key_count_reg + KCW'(1)
                                                          : key_count_reg;
                            key_count_next = '0;
                            n_next         = '0;
                            state_next     = ST_FILL;
                        end
                    end
                    else if (keyed_reg)
                    begin
                        i_next     = i_reg + 8'd1;
                        data_next  = req.byte_in;
                        state_next = ST_D_RDJ;
                    end
                end
            end
            ST_FILL:
            begin
                s_we   = 1'b1;
                n_next = n_reg + 8'd1;
                if (n_reg == SBOX_LAST)
                begin
                    acc_next   = '0;
                    pos_next   = '0;
                    state_next = ST_KS_RD;
                end
            end
            ST_KS_RD:
            begin
                state_next = ST_KS_ACC;
            end
            ST_KS_ACC:
            begin
                si_next    = s_rdata;
                acc_next   = acc_sum;
                s_raddr    = acc_sum;
                state_next = ST_KS_W1;
            end
            ST_KS_W1:
            begin
                s_we       = 1'b1;
                s_wdata    = s_rdata;
                state_next = ST_KS_W2;
            end
            ST_KS_W2:
            begin
                s_we    = 1'b1;
                s_waddr = acc_reg;
                s_wdata = si_reg;
                n_next  = n_reg + 8'd1;
                if (KCW'(pos_reg) + KCW'(1) >= len_reg)
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + KAW'(1);
                end
                if (n_reg == SBOX_LAST)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    keyed_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_KS_RD;
                end
            end
            ST_D_RDJ:
            begin
                si_next    = s_rdata;
                j_next     = j_reg + s_rdata;
                s_raddr    = j_reg + s_rdata;
                state_next = ST_D_W1;
            end
            ST_D_W1:
            begin
                sj_next    = s_rdata;
                s_we       = 1'b1;
                s_waddr    = i_reg;
                s_wdata    = s_rdata;
                state_next = ST_D_W2;
            end
            ST_D_W2:
            begin
                s_we       = 1'b1;
                s_waddr    = j_reg;
                s_wdata    = si_reg;
                state_next = ST_D_RDT;
            end
            ST_D_RDT:
            begin
                s_raddr    = si_reg + sj_reg;
                state_next = ST_D_KS;
            end
            ST_D_KS:
            begin
                // address held so the read data stays valid while output is full
                s_raddr = si_reg + sj_reg;
                if (out_ready)
                begin
                    rsp.done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_count_reg <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            n_reg         <= '0;
            acc_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            keyed_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            n_reg         <= n_next;
            acc_reg       <= acc_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            keyed_reg     <= keyed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        data_reg <= data_next;
    end

endmodule

### design/rc4_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit : RC4 stream cipher, one byte per transaction
// Key bytes are stored; the last key byte runs the key schedule. Data bytes
// are XORed with the keystream (same operation encrypts and decrypts).
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------
//  input   | in_valid / in_stall | operation, byte_in, last_key_byte
//  output  | out_valid/out_stall | byte_out
//
//  Key byte: stored at the key count (extra bytes past MAX_KEY_BYTES are
//  dropped). Last key byte: fills all 256 S-box entries, then runs 256
//  schedule steps (read, accumulate, two swap writes), all through the
//  single S-box RAM port. Data byte: the S[j] read, the two swap writes
//  and the keystream read, all on that same port, then the result goes to
//  the output register; the next transaction is taken after that.
//  Reset clears control state only; the S-box and key store are not cleared,
//  the key schedule fills the S-box. Data before the first key is dropped.
//  A result held in the output register stalls only the next data byte.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [7:0] byte_in,
    input  logic       last_key_byte,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] byte_out
);

    rc4_req_t req;
    rc4_rsp_t rsp;
    logic     out_ready;
    logic     out_valid_reg, out_valid_next;
    byte_t    byte_out_reg, byte_out_next;

    // input is refused whenever the sequencer is running
    assign in_stall = rsp.busy;

    assign req.accept        = in_valid && !in_stall;
    assign req.operation     = operation;
    assign req.byte_in       = byte_in;
    assign req.last_key_byte = last_key_byte;

    // output register is free when empty or its transaction completes now
    assign out_ready = !out_valid_reg || !out_stall;

    rc4_ctrl #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_ready (out_ready),
        .rsp       (rsp)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        byte_out_next  = byte_out_reg;
        if (rsp.done)
        begin
            out_valid_next = 1'b1;
            byte_out_next  = rsp.result;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_out_reg <= byte_out_next;
    end

    assign out_valid = out_valid_reg;
    assign byte_out  = byte_out_reg;

endmodule
